### rtl/tpc_pkg.sv
// Package with shared types, widths and constants of the 3-pole/3-zero compensator.
`default_nettype none

package tpc_pkg;

    localparam int TARGET_W   = 12;
    localparam int COEF_W     = 24;
    localparam int NUM_COEFS  = 7;
    localparam int HIST_DEPTH = 3;
    localparam int VAL_W      = 28;
    localparam int MUL_A_W    = 25;
    localparam int MUL_B_W    = 29;
    localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
    localparam int ACC_W      = 55;
    localparam int ACC_SHIFT  = 20;
    localparam int Y_FULL_W   = ACC_W - ACC_SHIFT;
    localparam int ERR_BASE_W = 32;
    localparam int FRAC_W     = 26;
    localparam int XDIV_W     = 24;
    localparam int QFRAC_W    = 14;
    localparam int SCALED_W   = 18;
    localparam int QUOT_W     = 17;
    localparam int WIDTH_W    = 16;
    localparam int HALF_W     = 15;
    localparam int OUT_TDATA_W = ((WIDTH_W + HALF_W + 7) / 8) * 8;
    localparam int CNT_W      = 3;

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    localparam int PERIOD_COUNTS_DEF = 46080;
    localparam int SAMPLE_BITS_DEF   = 12;

    // Error scaling: diff * 2^24 / 1000 = diff * 16777 + diff * 216 / 1000.
    localparam int ERR_SCALE_INT  = 16777;
    localparam int ERR_SCALE_FRAC = 216;
    localparam int ERR_BIAS_Q     = 885;
    localparam int ERR_OFFSET     = ERR_BIAS_Q * 1000 + 500;
    localparam int RECIP_1000       = 8589935;
    localparam int RECIP_1000_SHIFT = 33;

    localparam logic signed [ERR_BASE_W-1:0] ERR_MAX = 32'sd134217727;
    localparam logic signed [ERR_BASE_W-1:0] ERR_MIN = -32'sd134217728;

    localparam logic signed [Y_FULL_W-1:0] Y_CEIL_F = Y_FULL_W'(50331648);
    localparam logic signed [Y_FULL_W-1:0] Y_LOW_F  = Y_FULL_W'(1006633);
    localparam logic signed [VAL_W-1:0]    Y_CEIL_V = VAL_W'(50331648);
    localparam logic signed [VAL_W-1:0]    Y_LOW_V  = VAL_W'(1006633);
    localparam logic signed [VAL_W-1:0]    Y_HIGH_V = VAL_W'(46305116);

    localparam int SCALE_SHIFT   = 24;
    localparam int RECIP_3       = 174763;
    localparam int RECIP_3_SHIFT = 19;
    localparam logic [WIDTH_W-1:0] MIN_WIDTH = 16'd100;

    typedef enum logic [2:0] {
        REG_TARGET,
        REG_ERROR_NOW,
        REG_ERROR_ONE,
        REG_ERROR_TWO,
        REG_ERROR_THREE,
        REG_OUTPUT_ONE,
        REG_OUTPUT_TWO,
        REG_OUTPUT_THREE
    } reg_idx_t;

    typedef struct packed {
        logic [TARGET_W-1:0]                    target_level;
        logic [NUM_COEFS-1:0][COEF_W-1:0]       coefs;
    } cfg_t;

endpackage

`default_nettype wire

### rtl/tpc_mul.sv
// Shared signed multiplier with a registered product and load enable.
`default_nettype none

module tpc_mul
    import tpc_pkg::*;
#(
    parameter int A_W = MUL_A_W,
    parameter int B_W = MUL_B_W
)
(
    input  wire                        clk,
    input  wire                        en,
    input  wire logic signed [A_W-1:0] a,
    input  wire logic signed [B_W-1:0] b,
    output logic signed [A_W+B_W-1:0]  p
);

    logic signed [A_W+B_W-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= a * b;
        end
    end

    assign p = p_reg;

endmodule

`default_nettype wire

### rtl/tpc_cfg.sv
// Configuration register file with an APB-style port.
`default_nettype none

module tpc_cfg
    import tpc_pkg::*;
(
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         psel,
    input  wire                         penable,
    input  wire                         pwrite,
    input  wire logic [APB_ADDR_W-1:0]  paddr,
    input  wire logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]       prdata,
    output logic                        pready,
    output cfg_t                        cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_TARGET:       cfg_next.target_level = pwdata[TARGET_W-1:0];
                REG_ERROR_NOW:    cfg_next.coefs[0] = pwdata[COEF_W-1:0];
                REG_ERROR_ONE:    cfg_next.coefs[1] = pwdata[COEF_W-1:0];
                REG_ERROR_TWO:    cfg_next.coefs[2] = pwdata[COEF_W-1:0];
                REG_ERROR_THREE:  cfg_next.coefs[3] = pwdata[COEF_W-1:0];
                REG_OUTPUT_ONE:   cfg_next.coefs[4] = pwdata[COEF_W-1:0];
                REG_OUTPUT_TWO:   cfg_next.coefs[5] = pwdata[COEF_W-1:0];
                REG_OUTPUT_THREE: cfg_next.coefs[6] = pwdata[COEF_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_TARGET:
                prdata = {{(APB_DATA_W-TARGET_W){1'b0}}, cfg_reg.target_level};
            REG_ERROR_NOW:
                prdata = {{(APB_DATA_W-COEF_W){cfg_reg.coefs[0][COEF_W-1]}}, cfg_reg.coefs[0]};
            REG_ERROR_ONE:
                prdata = {{(APB_DATA_W-COEF_W){cfg_reg.coefs[1][COEF_W-1]}}, cfg_reg.coefs[1]};
            REG_ERROR_TWO:
                prdata = {{(APB_DATA_W-COEF_W){cfg_reg.coefs[2][COEF_W-1]}}, cfg_reg.coefs[2]};
            REG_ERROR_THREE:
                prdata = {{(APB_DATA_W-COEF_W){cfg_reg.coefs[3][COEF_W-1]}}, cfg_reg.coefs[3]};
            REG_OUTPUT_ONE:
                prdata = {{(APB_DATA_W-COEF_W){cfg_reg.coefs[4][COEF_W-1]}}, cfg_reg.coefs[4]};
            REG_OUTPUT_TWO:
                prdata = {{(APB_DATA_W-COEF_W){cfg_reg.coefs[5][COEF_W-1]}}, cfg_reg.coefs[5]};
            REG_OUTPUT_THREE:
                prdata = {{(APB_DATA_W-COEF_W){cfg_reg.coefs[6][COEF_W-1]}}, cfg_reg.coefs[6]};
            default:
                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target_level <= '0;
            cfg_reg.coefs[0]     <= COEF_W'(-435178);
            cfg_reg.coefs[1]     <= COEF_W'(392648);
            cfg_reg.coefs[2]     <= COEF_W'(435074);
            cfg_reg.coefs[3]     <= COEF_W'(-392751);
            cfg_reg.coefs[4]     <= COEF_W'(1167080);
            cfg_reg.coefs[5]     <= COEF_W'(-41497);
            cfg_reg.coefs[6]     <= COEF_W'(-77007);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

### rtl/three_pole_three_zero_compensator.sv
// Top level of the 3-pole/3-zero compensator: sequencer, datapath and output register.
//
// The input stream carries one output-voltage ADC sample per transaction in s_tdata.
// The output stream carries one PWM compare value and its half per transaction.
// Registers (target level and seven Q4.20 coefficients) are written over the APB
// port at byte address 4*i; the user must write them only while the block is
// idle, which the block itself does not enforce. pready is always high. Each
// sample runs through one shared registered multiplier: two products form the
// scaled error, seven products form the difference equation, and two more scale
// the limited output into timer counts. A result appears on m_tvalid when the
// sequencer leaves ST_FINISH, and s_tready rises in the same cycle, so the block
// takes no new sample until the last one is through the eleven multiplier passes.
// A finished result waits in the output register while the next sample is
// processed; if the receiver still stalls when the next result is ready, the
// sequencer holds until the output register is free. Reset clears the error and
// output history, loads the default coefficients and empties the output register.
`default_nettype none

module three_pole_three_zero_compensator
    import tpc_pkg::*;
#(
    parameter int PERIOD_COUNTS = PERIOD_COUNTS_DEF,
    parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF
)
(
    input  wire                                     clk,
    input  wire                                     rst_n,
    input  wire                                     s_tvalid,
    output logic                                    s_tready,
    // Fields from bit 0: vout_sample.
    input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]   s_tdata,
    output logic                                    m_tvalid,
    input  wire                                     m_tready,
    // Fields from bit 0: pulse_width (16), half_width (15).
    output logic [OUT_TDATA_W-1:0]                  m_tdata,
    input  wire                                     psel,
    input  wire                                     penable,
    input  wire                                     pwrite,
    input  wire logic [APB_ADDR_W-1:0]              paddr,
    input  wire logic [APB_DATA_W-1:0]              pwdata,
    output logic [APB_DATA_W-1:0]                   prdata,
    output logic                                    pready
);

    localparam int DIFF_W = ((SAMPLE_BITS > TARGET_W) ? SAMPLE_BITS : TARGET_W) + 1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ERR_MUL,
        ST_ERR_DIV,
        ST_ERR_SAT,
        ST_MAC,
        ST_LIMIT,
        ST_SCALE,
        ST_DIV3,
        ST_FINISH
    } state_t;

    cfg_t cfg;

    state_t                               state_reg, state_next;
    logic signed [DIFF_W-1:0]             diff_reg, diff_next;
    logic [XDIV_W-1:0]                    xdiv_reg, xdiv_next;
    logic signed [ERR_BASE_W-1:0]         err_base_reg, err_base_next;
    logic [VAL_W-1:0]                     err_reg, err_next;
    logic signed [ACC_W-1:0]              acc_reg, acc_next;
    logic [CNT_W-1:0]                     cnt_reg, cnt_next;
    logic [HIST_DEPTH-1:0][VAL_W-1:0]     err_hist_reg, err_hist_next;
    logic [HIST_DEPTH-1:0][VAL_W-1:0]     y_hist_reg, y_hist_next;
    logic [WIDTH_W-1:0]                   width_reg, width_next;
    logic                                 out_valid_reg, out_valid_next;

    logic                                 mul_en;
    logic signed [MUL_A_W-1:0]            mul_a;
    logic signed [MUL_B_W-1:0]            mul_b;
    logic signed [MUL_P_W-1:0]            mul_p;

    logic signed [FRAC_W-1:0]             diff_wide;
    logic signed [FRAC_W-1:0]             frac_sum;
    logic signed [ERR_BASE_W-1:0]         err_sum;
    logic [COEF_W-1:0]                    mac_coef;
    logic [VAL_W-1:0]                     mac_val;
    logic signed [Y_FULL_W-1:0]           y_full;
    logic [VAL_W-1:0]                     y_lim;
    logic [QUOT_W-1:0]                    quot;

    tpc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tpc_mul #(
        .A_W (MUL_A_W),
        .B_W (MUL_B_W)
    ) u_mul (
        .clk (clk),
        .en  (mul_en),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    assign diff_wide = {{(FRAC_W-DIFF_W){diff_reg[DIFF_W-1]}}, diff_reg};
    assign frac_sum  = diff_wide * $signed(FRAC_W'(ERR_SCALE_FRAC))
                     + $signed(FRAC_W'(ERR_OFFSET));
    assign err_sum   = err_base_reg
                     + $signed({{(ERR_BASE_W-QFRAC_W){1'b0}},
                                mul_p[RECIP_1000_SHIFT +: QFRAC_W]})
                     - $signed(ERR_BASE_W'(ERR_BIAS_Q));
    assign y_full    = acc_reg[ACC_W-1:ACC_SHIFT];
    assign quot      = mul_p[RECIP_3_SHIFT +: QUOT_W];

    always_comb
    begin
        case (cnt_reg)
            3'd0:    begin mac_coef = cfg.coefs[0]; mac_val = err_reg;         end
            3'd1:    begin mac_coef = cfg.coefs[1]; mac_val = err_hist_reg[0]; end
            3'd2:    begin mac_coef = cfg.coefs[2]; mac_val = err_hist_reg[1]; end
            3'd3:    begin mac_coef = cfg.coefs[3]; mac_val = err_hist_reg[2]; end
            3'd4:    begin mac_coef = cfg.coefs[4]; mac_val = y_hist_reg[0];   end
            3'd5:    begin mac_coef = cfg.coefs[5]; mac_val = y_hist_reg[1];   end
            3'd6:    begin mac_coef = cfg.coefs[6]; mac_val = y_hist_reg[2];   end
            default: begin mac_coef = '0;           mac_val = '0;              end
        endcase
    end

    always_comb
    begin
        if (y_full >= Y_CEIL_F)
        begin
            y_lim = Y_HIGH_V;
        end
        else if (y_full <= Y_LOW_F)
        begin
            y_lim = Y_LOW_V;
        end
        else
        begin
            y_lim = y_full[VAL_W-1:0];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        diff_next      = diff_reg;
        xdiv_next      = xdiv_reg;
        err_base_next  = err_base_reg;
        err_next       = err_reg;
        acc_next       = acc_reg;
        cnt_next       = cnt_reg;
        err_hist_next  = err_hist_reg;
        y_hist_next    = y_hist_reg;
        width_next     = width_reg;
        out_valid_next = out_valid_reg && !m_tready;
        mul_en         = 1'b0;
        mul_a          = '0;
        mul_b          = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    diff_next  = $signed({{(DIFF_W-SAMPLE_BITS){1'b0}},
                                          s_tdata[SAMPLE_BITS-1:0]})
                               - $signed({{(DIFF_W-TARGET_W){1'b0}}, cfg.target_level});
                    state_next = ST_ERR_MUL;
                end
            end
            ST_ERR_MUL:
            begin
                mul_en     = 1'b1;
                mul_a      = MUL_A_W'(ERR_SCALE_INT);
                mul_b      = {{(MUL_B_W-DIFF_W){diff_reg[DIFF_W-1]}}, diff_reg};
                xdiv_next  = frac_sum[XDIV_W-1:0];
                state_next = ST_ERR_DIV;
            end
            ST_ERR_DIV:
            begin
                mul_en        = 1'b1;
                mul_a         = MUL_A_W'(RECIP_1000);
                mul_b         = {{(MUL_B_W-XDIV_W){1'b0}}, xdiv_reg};
                err_base_next = mul_p[ERR_BASE_W-1:0];
                state_next    = ST_ERR_SAT;
            end
            ST_ERR_SAT:
            begin
                if (err_sum > ERR_MAX)
                begin
                    err_next = ERR_MAX[VAL_W-1:0];
                end
                else if (err_sum < ERR_MIN)
                begin
                    err_next = ERR_MIN[VAL_W-1:0];
                end
                else
                begin
                    err_next = err_sum[VAL_W-1:0];
                end
                acc_next   = '0;
                cnt_next   = '0;
                state_next = ST_MAC;
            end
            ST_MAC:
            begin
                if (cnt_reg != CNT_W'(NUM_COEFS))
                begin
                    mul_en = 1'b1;
                    mul_a  = {mac_coef[COEF_W-1], mac_coef};
                    mul_b  = {mac_val[VAL_W-1], mac_val};
                end
                if (cnt_reg != '0)
                begin
                    acc_next = acc_reg + {{(ACC_W-MUL_P_W){mul_p[MUL_P_W-1]}}, mul_p};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(NUM_COEFS))
                begin
                    state_next = ST_LIMIT;
                end
            end
            ST_LIMIT:
            begin
                err_hist_next = {err_hist_reg[HIST_DEPTH-2:0], err_reg};
                y_hist_next   = {y_hist_reg[HIST_DEPTH-2:0], y_lim};
                state_next    = ST_SCALE;
            end
            ST_SCALE:
            begin
                mul_en     = 1'b1;
                mul_a      = MUL_A_W'(PERIOD_COUNTS);
                mul_b      = {y_hist_reg[0][VAL_W-1], y_hist_reg[0]};
                state_next = ST_DIV3;
            end
            ST_DIV3:
            begin
                mul_en     = 1'b1;
                mul_a      = MUL_A_W'(RECIP_3);
                mul_b      = {{(MUL_B_W-SCALED_W){1'b0}}, mul_p[SCALE_SHIFT +: SCALED_W]};
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    if (quot <= {{(QUOT_W-WIDTH_W){1'b0}}, MIN_WIDTH})
                    begin
                        width_next = MIN_WIDTH;
                    end
                    else
                    begin
                        width_next = quot[WIDTH_W-1:0];
                    end
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            err_hist_reg  <= '0;
            y_hist_reg    <= '0;
            width_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            err_hist_reg  <= err_hist_next;
            y_hist_reg    <= y_hist_next;
            width_reg     <= width_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        diff_reg     <= diff_next;
        xdiv_reg     <= xdiv_next;
        err_base_reg <= err_base_next;
        err_reg      <= err_next;
        acc_reg      <= acc_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W-WIDTH_W-HALF_W){1'b0}},
                       width_reg[WIDTH_W-1:1], width_reg};

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("Input accepted again right after a transaction.");

    a_min_width: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[WIDTH_W-1:0] >= MIN_WIDTH))
        else $error("Pulse width below the minimum.");

    a_half_width: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[WIDTH_W +: HALF_W] == m_tdata[WIDTH_W-1:1]))
        else $error("Half width does not match the pulse width.");

    a_output_limited: assert property (@(posedge clk) disable iff (!rst_n)
        (y_hist_reg[0] == '0)
        || (($signed(y_hist_reg[0]) >= Y_LOW_V) && ($signed(y_hist_reg[0]) < Y_CEIL_V)))
        else $error("Stored output outside the limiter range.");
`endif

endmodule

`default_nettype wire

### sim/tpc_loop_checker.sv
// Checker for the compensator: tracks register writes, predicts each result and compares it.
`timescale 1ns / 100ps

module tpc_loop_checker
    import tpc_pkg::*;
(
    input  wire                                         clk,
    input  wire                                         rst_n,
    input  wire                                         s_tvalid,
    input  wire                                         s_tready,
    // Fields from bit 0: vout_sample.
    input  wire logic [((SAMPLE_BITS_DEF+7)/8)*8-1:0]   s_tdata,
    input  wire                                         m_tvalid,
    input  wire                                         m_tready,
    // Fields from bit 0: pulse_width (16), half_width (15).
    input  wire logic [OUT_TDATA_W-1:0]                 m_tdata,
    input  wire                                         psel,
    input  wire                                         penable,
    input  wire                                         pwrite,
    input  wire                                         pready,
    input  wire logic [APB_ADDR_W-1:0]                  paddr,
    input  wire logic [APB_DATA_W-1:0]                  pwdata,
    output int                                          mismatches,
    output int                                          outstanding
);

    localparam int     REPORT_CAP   = 200;
    localparam longint ONE_Q24      = longint'(1) << SCALE_SHIFT;
    localparam longint ERR_HI       = longint'(ERR_MAX);
    localparam longint ERR_LO       = longint'(ERR_MIN);
    localparam longint Y_CEILING    = longint'(Y_CEIL_V);
    localparam longint Y_FLOOR      = longint'(Y_LOW_V);
    localparam longint Y_RECOVER    = longint'(Y_HIGH_V);
    localparam longint PERIOD       = longint'(PERIOD_COUNTS_DEF);
    localparam longint SHORTEST     = longint'(MIN_WIDTH);

    localparam logic signed [COEF_W-1:0] RESET_COEFS [NUM_COEFS] = '{
        -24'sd435178, 24'sd392648, 24'sd435074, -24'sd392751,
        24'sd1167080, -24'sd41497, -24'sd77007
    };

    typedef struct {
        logic [WIDTH_W-1:0] pulse_width;
        logic [HALF_W-1:0]  half_width;
    } widths_t;

    logic [TARGET_W-1:0]      target_level;
    logic signed [COEF_W-1:0] coef [NUM_COEFS];
    longint                   error_past [HIST_DEPTH];
    longint                   output_past [HIST_DEPTH];
    widths_t                  width_queue [$];
    int                       fail_count = 0;

    assign mismatches = fail_count;

    task automatic report_mismatch(input string what);
        if (fail_count < REPORT_CAP)
            $display("%0t ns: mismatch: %s", $time, what);
        fail_count++;
    endtask

    // Runs one control step on the model state and returns the compare values.
    function automatic widths_t step_compensator(input logic [SAMPLE_BITS_DEF-1:0] sample);
        longint  diff;
        longint  num;
        longint  err;
        longint  acc;
        longint  y;
        longint  width;
        widths_t w;
        diff = longint'(sample) - longint'(target_level);
        num  = diff * ONE_Q24 + 500;
        if (num >= 0)
            err = num / 1000;
        else
            err = -((-num + 999) / 1000);
        if (err > ERR_HI)
            err = ERR_HI;
        if (err < ERR_LO)
            err = ERR_LO;

        acc = longint'(coef[0]) * err;
        for (int i = 0; i < HIST_DEPTH; i++)
        begin
            acc += longint'(coef[1 + i]) * error_past[i];
            acc += longint'(coef[1 + HIST_DEPTH + i]) * output_past[i];
        end
        y = acc >>> ACC_SHIFT;
        if (y >= Y_CEILING)
            y = Y_RECOVER;
        else if (y <= Y_FLOOR)
            y = Y_FLOOR;

        for (int i = HIST_DEPTH - 1; i > 0; i--)
        begin
            error_past[i]  = error_past[i - 1];
            output_past[i] = output_past[i - 1];
        end
        error_past[0]  = err;
        output_past[0] = y;

        width = (y * PERIOD) / Y_CEILING;
        if (width <= SHORTEST)
            width = SHORTEST;
        w.pulse_width = WIDTH_W'(width);
        w.half_width  = HALF_W'(w.pulse_width >> 1);
        return w;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        widths_t    due;
        reg_idx_t   idx;
        if (!rst_n)
        begin
            target_level = '0;
            coef         = RESET_COEFS;
            for (int i = 0; i < HIST_DEPTH; i++)
            begin
                error_past[i]  = 0;
                output_past[i] = 0;
            end
            width_queue.delete();
            outstanding <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                idx = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
                if (idx == REG_TARGET)
                    target_level = pwdata[TARGET_W-1:0];
                else
                    coef[int'(idx) - int'(REG_ERROR_NOW)] = pwdata[COEF_W-1:0];
            end
            if (m_tvalid && m_tready)
            begin
                if (width_queue.size() == 0)
                    report_mismatch($sformatf("result 0x%h with no sample pending", m_tdata));
                else
                begin
                    due = width_queue.pop_front();
                    if (m_tdata[WIDTH_W-1:0] !== due.pulse_width)
                        report_mismatch($sformatf("pulse_width %0d, expected %0d",
                                                  m_tdata[WIDTH_W-1:0], due.pulse_width));
                    if (m_tdata[WIDTH_W +: HALF_W] !== due.half_width)
                        report_mismatch($sformatf("half_width %0d, expected %0d",
                                                  m_tdata[WIDTH_W +: HALF_W], due.half_width));
                end
            end
            if (s_tvalid && s_tready)
                width_queue.push_back(step_compensator(s_tdata[SAMPLE_BITS_DEF-1:0]));
            outstanding <= width_queue.size();
        end
    end

endmodule

### sim/three_pole_three_zero_compensator_tb.sv
// Testbench top for the compensator: clock, reset, register loads, sample stimulus and verdict.
`timescale 1ns / 100ps

module three_pole_three_zero_compensator_tb;
    import tpc_pkg::*;

    localparam int SAMPLE_W          = SAMPLE_BITS_DEF;
    localparam int IN_TDATA_W        = ((SAMPLE_W + 7) / 8) * 8;
    localparam int SAMPLE_MAX        = (1 << SAMPLE_W) - 1;
    localparam int TARGET_MAX        = (1 << TARGET_W) - 1;
    localparam int ITEMS_PER_SETTING = 190;
    localparam int CHUNK_ITEMS       = 25;
    localparam int CALM_ITEMS        = 150;
    localparam int SETTLE_CYCLES     = 20;
    localparam int CYCLE_LIMIT       = 400000;
    localparam int GAP_PCTS [3]      = '{0, 15, 40};

    localparam logic signed [COEF_W-1:0] NOMINAL_COEFS [NUM_COEFS] = '{
        -24'sd435178, 24'sd392648, 24'sd435074, -24'sd392751,
        24'sd1167080, -24'sd41497, -24'sd77007
    };

    localparam logic [SAMPLE_W-1:0] DIRECTED_SAMPLES [22] = '{
        12'd2048, 12'd2048, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0,
        12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095,
        12'd2048, 12'd1, 12'd4094, 12'hAAA, 12'h555, 12'd4095, 12'd0, 12'd2048
    };

    typedef enum {
        PERTURBED,
        NOMINAL_LOW_TARGET,
        FULL_RANGE,
        ALL_MAX,
        NOMINAL_HIGH_TARGET,
        ALL_MIN,
        MILD,
        NOMINAL
    } setting_kind_t;

    typedef enum {
        NEAR_TARGET,
        ANY_LEVEL,
        NEAR_LEVEL,
        RAIL_TO_RAIL
    } drive_t;

    logic                     clk      = 1'b0;
    logic                     rst_n    = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic [IN_TDATA_W-1:0]    s_tdata  = '0;
    logic                     m_tready = 1'b0;
    logic                     psel     = 1'b0;
    logic                     penable  = 1'b0;
    logic                     pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0]    paddr    = '0;
    logic [APB_DATA_W-1:0]    pwdata   = '0;
    wire                      s_tready;
    wire                      m_tvalid;
    wire  [OUT_TDATA_W-1:0]   m_tdata;
    wire  [APB_DATA_W-1:0]    prdata;
    wire                      pready;

    int                       mismatches;
    int                       outstanding;
    int                       sample_gap_pct = 0;
    int                       ready_gap_pct  = 0;
    int                       stall_left     = 0;
    int                       cycle_count    = 0;
    logic [TARGET_W-1:0]      target;
    logic signed [COEF_W-1:0] coef_set [NUM_COEFS];

    three_pole_three_zero_compensator uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    tpc_loop_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Receiver back-pressure comes in bursts whose length is drawn at random.
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if ($urandom_range(99) < ready_gap_pct)
        begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(2);
        end
        else
            m_tready <= 1'b1;
    end

    task automatic write_reg(input reg_idx_t r, input logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(int'(r) * 4);
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
    endtask

    // Upper data bits are random: the block must ignore them.
    task automatic load_settings();
        write_reg(REG_TARGET, {(APB_DATA_W - TARGET_W)'($urandom), target});
        for (int i = 0; i < NUM_COEFS; i++)
            write_reg(reg_idx_t'(int'(REG_ERROR_NOW) + i),
                      {(APB_DATA_W - COEF_W)'($urandom), coef_set[i]});
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_sample(input logic [SAMPLE_W-1:0] value);
        if ($urandom_range(99) < sample_gap_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_TDATA_W'(value);
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample(input drive_t drive, input int level);
        int v;
        case (drive)
            NEAR_TARGET: v = int'(target) + int'($urandom_range(64)) - 32;
            ANY_LEVEL:   v = $urandom_range(SAMPLE_MAX);
            NEAR_LEVEL:  v = level + int'($urandom_range(16)) - 8;
            default:     v = $urandom_range(1) ? SAMPLE_MAX : 0;
        endcase
        if (v < 0)
            v = 0;
        if (v > SAMPLE_MAX)
            v = SAMPLE_MAX;
        return SAMPLE_W'(v);
    endfunction

    initial
    begin
        setting_kind_t kind;
        drive_t        drive;
        int            level;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        sample_gap_pct = GAP_PCTS[1];
        ready_gap_pct  = GAP_PCTS[1];
        target         = TARGET_W'(1 << (TARGET_W - 1));
        coef_set       = NOMINAL_COEFS;
        load_settings();
        foreach (DIRECTED_SAMPLES[i])
            send_sample(DIRECTED_SAMPLES[i]);
        drain();

        for (int k = 0; k < kind.num(); k++)
        begin
            kind     = setting_kind_t'(k);
            target   = TARGET_W'($urandom_range(TARGET_MAX));
            coef_set = NOMINAL_COEFS;
            case (kind)
                PERTURBED:
                    foreach (coef_set[i])
                        coef_set[i] = COEF_W'(int'(NOMINAL_COEFS[i])
                                              + int'($urandom_range(65536)) - 32768);
                NOMINAL_LOW_TARGET:
                    target = '0;
                NOMINAL_HIGH_TARGET:
                    target = TARGET_W'(TARGET_MAX);
                FULL_RANGE:
                    foreach (coef_set[i])
                        coef_set[i] = COEF_W'($urandom);
                ALL_MAX:
                    foreach (coef_set[i])
                        coef_set[i] = {1'b0, {(COEF_W - 1){1'b1}}};
                ALL_MIN:
                    foreach (coef_set[i])
                        coef_set[i] = {1'b1, {(COEF_W - 1){1'b0}}};
                MILD:
                    foreach (coef_set[i])
                        coef_set[i] = COEF_W'(int'($urandom_range(1 << 20)) - (1 << 19));
                default:
                    ;
            endcase
            load_settings();

            for (int n = 0; n < ITEMS_PER_SETTING; n++)
            begin
                if (n % CHUNK_ITEMS == 0)
                begin
                    drive          = drive_t'($urandom_range(drive.num() - 1));
                    level          = $urandom_range(SAMPLE_MAX);
                    sample_gap_pct = GAP_PCTS[$urandom_range(2)];
                    ready_gap_pct  = GAP_PCTS[$urandom_range(2)];
                end
                if (k == kind.num() - 1 && n >= ITEMS_PER_SETTING - CALM_ITEMS)
                begin
                    sample_gap_pct = 0;
                    ready_gap_pct  = 0;
                end
                send_sample(pick_sample(drive, level));
            end
            drain();
        end

        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
